// ----- rtl/core/vbfm_pkg.sv -----
package vbfm_pkg;

  localparam int WORD_BITS     = 32;
  localparam int MAX_ROW_WORDS = 8;
  localparam int MAX_ROWS      = 64;
  localparam int MAX_PLANES    = 256;

  localparam int WX_W   = $clog2(MAX_ROW_WORDS);
  localparam int RY_W   = $clog2(MAX_ROWS);
  localparam int PZ_W   = $clog2(MAX_PLANES);
  localparam int PP_W   = PZ_W + 1;
  localparam int ADDR_W = 1 + RY_W + WX_W;
  localparam int MEM_DEPTH = 2 * MAX_ROWS * MAX_ROW_WORDS;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int RW_REG_W   = 4;
  localparam int RP_REG_W   = 7;
  localparam int PC_REG_W   = 9;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam int OUT_BITS = WX_W + RY_W + PZ_W + 6 * WORD_BITS;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WORDS  = 2'd0,
    CFG_ROWS       = 2'd1,
    CFG_PLANES     = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic emit;
    logic wr;
    logic has_left;
    logic has_right;
    logic has_up;
    logic has_down;
    logic has_zn;
    logic has_zp;
    logic vend;
  } cmd_flags_t;

  typedef struct packed {
    logic [WX_W-1:0]      w;
    logic [RY_W-1:0]      r;
    logic [PP_W-1:0]      p;
    logic [WORD_BITS-1:0] data;
    cmd_flags_t           flags;
  } cmd_t;

endpackage

// ----- rtl/core/vbfm_front.sv -----
module vbfm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vbfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vbfm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  input  logic [vbfm_pkg::WORD_BITS-1:0] in_data,
  input  logic                          q_full,
  output logic                          in_ready,
  output logic                          q_push,
  output vbfm_pkg::cmd_t                q_cmd
);

  logic [vbfm_pkg::RW_REG_W-1:0] row_words_r;
  logic [vbfm_pkg::RP_REG_W-1:0] rows_r;
  logic [vbfm_pkg::PC_REG_W-1:0] planes_r;
  logic [vbfm_pkg::WX_W-1:0]     w_r, w_nxt, w_cur;
  logic [vbfm_pkg::RY_W-1:0]     r_r, r_nxt, r_cur;
  logic [vbfm_pkg::PP_W-1:0]     p_r, p_nxt, p_cur;
  logic                          w_last, r_last;
  logic [vbfm_pkg::RW_REG_W-1:0] w_inc;
  logic [vbfm_pkg::RP_REG_W-1:0] r_inc;
  vbfm_pkg::cfg_idx_t            idx;

  function automatic logic [vbfm_pkg::CFG_DATA_W-1:0] clamp_val(
    input logic [vbfm_pkg::CFG_DATA_W-1:0] v,
    input logic [vbfm_pkg::CFG_DATA_W-1:0] hi
  );
    logic [vbfm_pkg::CFG_DATA_W-1:0] res;
    if (v == '0) begin
      res = vbfm_pkg::CFG_DATA_W'(1);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  assign idx      = vbfm_pkg::cfg_idx_t'(cfg_index);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // out-of-range position restarts the volume
  always_comb begin
    w_cur = w_r;
    r_cur = r_r;
    p_cur = p_r;
    if ({1'b0, w_r} >= row_words_r || {1'b0, r_r} >= rows_r || p_r > planes_r) begin
      w_cur = '0;
      r_cur = '0;
      p_cur = '0;
    end
  end

  assign w_inc  = {1'b0, w_cur} + vbfm_pkg::RW_REG_W'(1);
  assign r_inc  = {1'b0, r_cur} + vbfm_pkg::RP_REG_W'(1);
  assign w_last = (w_inc == row_words_r);
  assign r_last = (r_inc == rows_r);

  always_comb begin
    q_cmd.w    = w_cur;
    q_cmd.r    = r_cur;
    q_cmd.p    = p_cur;
    q_cmd.data = in_data;
    q_cmd.flags.emit      = (p_cur != '0);
    q_cmd.flags.wr        = (p_cur < planes_r);
    q_cmd.flags.has_left  = (w_cur != '0);
    q_cmd.flags.has_right = !w_last;
    q_cmd.flags.has_up    = (r_cur != '0);
    q_cmd.flags.has_down  = !r_last;
    q_cmd.flags.has_zn    = (p_cur >= vbfm_pkg::PP_W'(2));
    q_cmd.flags.has_zp    = (p_cur < planes_r);
    q_cmd.flags.vend      = (p_cur == planes_r) && r_last && w_last;
  end

  always_comb begin
    w_nxt = w_inc[vbfm_pkg::WX_W-1:0];
    r_nxt = r_cur;
    p_nxt = p_cur;
    if (w_last) begin
      w_nxt = '0;
      r_nxt = r_inc[vbfm_pkg::RY_W-1:0];
      if (r_last) begin
        r_nxt = '0;
        p_nxt = (p_cur == planes_r) ? '0 : p_cur + vbfm_pkg::PP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_words_r <= vbfm_pkg::RW_REG_W'(8);
      rows_r      <= vbfm_pkg::RP_REG_W'(64);
      planes_r    <= vbfm_pkg::PC_REG_W'(64);
      w_r <= '0;
      r_r <= '0;
      p_r <= '0;
    end else if (cfg_we && idx != vbfm_pkg::CFG_UNUSED) begin
      case (idx)
        vbfm_pkg::CFG_ROW_WORDS: row_words_r <= vbfm_pkg::RW_REG_W'(clamp_val(
          {5'd0, cfg_wdata[3:0]}, vbfm_pkg::CFG_DATA_W'(vbfm_pkg::MAX_ROW_WORDS)));
        vbfm_pkg::CFG_ROWS: rows_r <= vbfm_pkg::RP_REG_W'(clamp_val(
          {2'd0, cfg_wdata[6:0]}, vbfm_pkg::CFG_DATA_W'(vbfm_pkg::MAX_ROWS)));
        vbfm_pkg::CFG_PLANES: planes_r <= vbfm_pkg::PC_REG_W'(clamp_val(
          cfg_wdata, vbfm_pkg::CFG_DATA_W'(vbfm_pkg::MAX_PLANES)));
        default: ;
      endcase
      w_r <= '0;
      r_r <= '0;
      p_r <= '0;
    end else if (q_push) begin
      w_r <= w_nxt;
      r_r <= r_nxt;
      p_r <= p_nxt;
    end
  end

endmodule

// ----- rtl/core/vbfm_fifo.sv -----
module vbfm_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vbfm_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output vbfm_pkg::cmd_t head
);

  vbfm_pkg::cmd_t                  slot_r [vbfm_pkg::FIFO_DEPTH];
  logic [vbfm_pkg::FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [vbfm_pkg::FIFO_PTR_W:0]   cnt_r;

  assign full      = (cnt_r == (vbfm_pkg::FIFO_PTR_W+1)'(vbfm_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/vbfm_back.sv -----
module vbfm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  vbfm_pkg::cmd_t                  q_cmd,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vbfm_pkg::OUT_DATA_W-1:0] out_data,
  output logic                            out_last
);

  localparam int WB = vbfm_pkg::WORD_BITS;
  localparam int AW = vbfm_pkg::ADDR_W;

  // three copies of the plane store, two read ports each
  logic [WB-1:0] mem_a [vbfm_pkg::MEM_DEPTH];
  logic [WB-1:0] mem_b [vbfm_pkg::MEM_DEPTH];
  logic [WB-1:0] mem_c [vbfm_pkg::MEM_DEPTH];

  logic [AW-1:0] a_cur, a_left, a_right, a_up, a_down, a_old;
  logic          cb, wb;

  logic [WB-1:0] c_r, l_r, rt_r, u_r, d_r, o_r;
  vbfm_pkg::cmd_t s1_r;
  logic           s1_vld_r, s1_adv, s1_load;

  logic [WB-1:0] left, right, xn, xp, yn, yp, zn, zp;
  logic          out_vld_r;
  logic [vbfm_pkg::OUT_DATA_W-1:0] out_data_r;
  logic          out_last_r;

  assign cb = ~q_cmd.p[0];
  assign wb = q_cmd.p[0];
  assign a_cur   = {cb, q_cmd.r, q_cmd.w};
  assign a_left  = {cb, q_cmd.r, q_cmd.w - 1'b1};
  assign a_right = {cb, q_cmd.r, q_cmd.w + 1'b1};
  assign a_up    = {cb, q_cmd.r - 1'b1, q_cmd.w};
  assign a_down  = {cb, q_cmd.r + 1'b1, q_cmd.w};
  assign a_old   = {wb, q_cmd.r, q_cmd.w};

  assign s1_adv  = !s1_r.flags.emit || !out_vld_r || out_ready;
  assign s1_load = !s1_vld_r || s1_adv;
  assign q_pop   = q_valid && s1_load;

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.flags.wr) mem_a[a_old] <= q_cmd.data;
    if (q_pop) begin
      c_r <= mem_a[a_cur];
      l_r <= mem_a[a_left];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.flags.wr) mem_b[a_old] <= q_cmd.data;
    if (q_pop) begin
      rt_r <= mem_b[a_right];
      u_r  <= mem_b[a_up];
    end
  end

  // older plane read shares the write address, returns the old word
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.flags.wr) mem_c[a_old] <= q_cmd.data;
    if (q_pop) begin
      d_r <= mem_c[a_down];
      o_r <= mem_c[a_old];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) s1_r <= q_cmd;
  end

  always_comb begin
    left  = {c_r[WB-2:0], s1_r.flags.has_left ? l_r[WB-1] : 1'b0};
    right = {s1_r.flags.has_right ? rt_r[0] : 1'b0, c_r[WB-1:1]};
    xn = c_r & ~left;
    xp = c_r & ~right;
    yn = s1_r.flags.has_up   ? (c_r & ~u_r) : c_r;
    yp = s1_r.flags.has_down ? (c_r & ~d_r) : c_r;
    zn = s1_r.flags.has_zn   ? (c_r & ~o_r) : c_r;
    zp = s1_r.flags.has_zp   ? (c_r & ~s1_r.data) : c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_load) s1_vld_r <= q_valid;
      if (s1_vld_r && s1_r.flags.emit && s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_r.flags.emit && s1_adv) begin
      out_data_r <= vbfm_pkg::OUT_DATA_W'({zp, zn, yp, yn, xp, xn,
        vbfm_pkg::PZ_W'(s1_r.p - 1'b1), s1_r.r, s1_r.w});
      out_last_r <= s1_r.flags.vend;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

// ----- rtl/core/voxel_boundary_face_mask_top.sv -----
// channel | dir | payload
// in_     | in  | tdata: voxel_bits
// out_    | out | tdata: word_x, row_y, plane_z, six face masks; tlast: volume_end
// cfg_    | in  | cfg_index selects row_words / rows_per_plane / plane_count
//
// one request per cycle sustained while the output does not stall; a result leaves once the word
// of the next plane that completes it has passed the queue, the store read and the mask stage
// rate is set by the plane store, three copies each read at two addresses a cycle
// rst_n is synchronous; config and position reset, store contents left undefined
// a 4-entry command queue lets the input keep flowing while the output stalls
module voxel_boundary_face_mask_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vbfm_pkg::WORD_BITS-1:0]    in_tdata,   // voxel_bits
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // word_x, row_y, plane_z, face_xneg, face_xpos, face_yneg, face_ypos,
  // face_zneg, face_zpos, zero fill
  output logic [vbfm_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [vbfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vbfm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic           q_full, q_push, q_pop, q_valid;
  vbfm_pkg::cmd_t push_cmd, head_cmd;

  // front: position tracking and neighbour classification
  vbfm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .q_full    (q_full),
    .in_ready  (in_tready),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  vbfm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head_cmd)
  );

  // back: plane store, mask computation, output register
  vbfm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ----- dv/tb_voxel_boundary_face_mask_top.sv -----
`timescale 1ns / 1ps

module tb_voxel_boundary_face_mask_top;

  localparam int WORD_BITS     = vbfm_pkg::WORD_BITS;
  localparam int MAX_ROW_WORDS = vbfm_pkg::MAX_ROW_WORDS;
  localparam int MAX_ROWS      = vbfm_pkg::MAX_ROWS;
  localparam int MAX_PLANES    = vbfm_pkg::MAX_PLANES;
  localparam int WX_W          = vbfm_pkg::WX_W;
  localparam int RY_W          = vbfm_pkg::RY_W;
  localparam int PZ_W          = vbfm_pkg::PZ_W;
  localparam int OUT_DATA_W    = vbfm_pkg::OUT_DATA_W;
  localparam int CFG_IDX_W     = vbfm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = vbfm_pkg::CFG_DATA_W;
  localparam int RW_REG_W      = vbfm_pkg::RW_REG_W;
  localparam int RP_REG_W      = vbfm_pkg::RP_REG_W;
  localparam int PC_REG_W      = vbfm_pkg::PC_REG_W;

  typedef vbfm_pkg::cfg_idx_t cfg_idx_t;

  localparam int BANK      = MAX_ROWS * MAX_ROW_WORDS;
  localparam int IDLE_WAIT = 24;    // queue plus the store read and output stages, with margin
  localparam int WD_LIMIT  = 3000;  // cycles with no transfer of any kind
  localparam int MX0 = WX_W + RY_W + PZ_W;

  // one pending stimulus entry: either a voxel word or a register write
  typedef struct {
    bit              is_cfg;
    cfg_idx_t        idx;
    logic [CFG_DATA_W-1:0] val;
    logic [WORD_BITS-1:0]  word;
  } stim_t;

  // one expected face record
  typedef struct {
    logic [WX_W-1:0]      wx;
    logic [RY_W-1:0]      ry;
    logic [PZ_W-1:0]      pz;
    logic [WORD_BITS-1:0] xn, xp, yn, yp, zn, zp;
    logic                 vend;
  } faces_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [WORD_BITS-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  voxel_boundary_face_mask_top dut (.*);

  always #5 clk = ~clk;

  stim_t  stim_q[$];
  faces_t pending_faces[$];
  int     errors = 0;

  // predictor state: two plane banks, stream position, clamped registers
  logic [WORD_BITS-1:0] plane_mem [0:2*BANK-1];
  int wpos, rpos, ppos;
  int row_words, rows_per_plane, plane_count;

  task automatic report(input string what, input logic [WORD_BITS-1:0] got,
                        input logic [WORD_BITS-1:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic int clamp(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic apply_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    case (idx)
      vbfm_pkg::CFG_ROW_WORDS: row_words      = clamp(v[RW_REG_W-1:0], MAX_ROW_WORDS);
      vbfm_pkg::CFG_ROWS:      rows_per_plane = clamp(v[RP_REG_W-1:0], MAX_ROWS);
      vbfm_pkg::CFG_PLANES:    plane_count    = clamp(v[PC_REG_W-1:0], MAX_PLANES);
      default:                 return;
    endcase
    wpos = 0;
    rpos = 0;
    ppos = 0;
  endtask

  function automatic int addr(input int bank, input int r, input int w);
    return (bank & 1) * BANK + r * MAX_ROW_WORDS + w;
  endfunction

  task automatic predict_faces(input logic [WORD_BITS-1:0] cur);
    int w, r, p, cb, ob;
    logic [WORD_BITS-1:0] c, left, right;
    faces_t f;
    w = wpos; r = rpos; p = ppos;
    if (w >= row_words || r >= rows_per_plane || p > plane_count) begin
      w = 0; r = 0; p = 0;
    end
    if (p >= 1) begin
      cb = (p - 1) & 1;
      ob = p & 1;
      c = plane_mem[addr(cb, r, w)];
      left = c << 1;
      right = c >> 1;
      if (w > 0) left |= plane_mem[addr(cb, r, w - 1)] >> (WORD_BITS - 1);
      if (w + 1 < row_words) right |= plane_mem[addr(cb, r, w + 1)] << (WORD_BITS - 1);
      f.wx = WX_W'(w);
      f.ry = RY_W'(r);
      f.pz = PZ_W'(p - 1);
      f.xn = c & ~left;
      f.xp = c & ~right;
      f.yn = (r > 0) ? (c & ~plane_mem[addr(cb, r - 1, w)]) : c;
      f.yp = (r + 1 < rows_per_plane) ? (c & ~plane_mem[addr(cb, r + 1, w)]) : c;
      f.zn = (p >= 2) ? (c & ~plane_mem[addr(ob, r, w)]) : c;
      // padding plane counts as empty
      f.zp = (p < plane_count) ? (c & ~cur) : c;
      f.vend = (p == plane_count && r + 1 == rows_per_plane && w + 1 == row_words);
      pending_faces.push_back(f);
    end
    if (p < plane_count) plane_mem[addr(p, r, w)] = cur;
    w++;
    if (w >= row_words) begin
      w = 0;
      r++;
      if (r >= rows_per_plane) begin
        r = 0;
        p++;
        if (p > plane_count) p = 0;
      end
    end
    wpos = w; rpos = r; ppos = p;
  endtask

  // ---------------- stimulus building ----------------
  function automatic logic [WORD_BITS-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom & $urandom;  // sparse
      3:       return $urandom | $urandom;  // dense
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cfg(input cfg_idx_t idx, input int v);
    stim_t s;
    s.is_cfg = 1; s.idx = idx; s.val = CFG_DATA_W'(v); s.word = '0;
    stim_q.push_back(s);
  endtask

  task automatic push_word(input logic [WORD_BITS-1:0] wd);
    stim_t s;
    s.is_cfg = 0; s.idx = vbfm_pkg::CFG_UNUSED; s.val = '0; s.word = wd;
    stim_q.push_back(s);
  endtask

  // register values as written; n_items words follow
  task automatic push_phase(input int rw, input int rp, input int pc, input int n_items);
    push_cfg(vbfm_pkg::CFG_ROW_WORDS, rw);
    push_cfg(vbfm_pkg::CFG_ROWS, rp);
    push_cfg(vbfm_pkg::CFG_PLANES, pc);
    repeat (n_items) push_word(rand_word());
  endtask

  function automatic int vol_items(input int rw, input int rp, input int pc);
    return clamp(rw, MAX_ROW_WORDS) * clamp(rp, MAX_ROWS) * (clamp(pc, MAX_PLANES) + 1);
  endfunction

  // ---------------- driver ----------------
  int  gap_left = 0;
  int  idle_cnt = 0;
  bit  burst_mode = 0;
  int  sent = 0;

  function automatic int pick_gap(input int limit_long);
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, limit_long);
  endfunction

  always @(posedge clk) begin
    logic  valid_n;
    logic  cfg_n;
    stim_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      valid_n = in_tvalid;
      cfg_n = 1'b0;
      if (in_tvalid && in_tready) begin
        predict_faces(in_tdata);
        valid_n = 1'b0;
      end
      // quiet time before a register write
      if (pending_faces.size() == 0 && !in_tvalid) idle_cnt++;
      else idle_cnt = 0;
      if (!valid_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          s = stim_q[0];
          if (s.is_cfg) begin
            // only once the block has drained completely
            if (idle_cnt >= IDLE_WAIT) begin
              cfg_n = 1'b1;
              cfg_index <= s.idx;
              cfg_wdata <= s.val;
              apply_cfg(s.idx, s.val);
              void'(stim_q.pop_front());
            end
          end else begin
            in_tdata <= s.word;
            valid_n = 1'b1;
            void'(stim_q.pop_front());
            sent++;
            if (sent % 97 == 0) burst_mode = ~burst_mode;
            gap_left = burst_mode ? 0 : pick_gap(40);
          end
        end
      end
      cfg_we <= cfg_n;
      in_tvalid <= valid_n;
    end
  end

  // ---------------- monitor ----------------
  int  stall_left = 0;
  int  results_seen = 0;
  bit  long_hold_done = 0;

  always @(posedge clk) begin
    faces_t f;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_faces.size() == 0) begin
          $display("unexpected face record %h", out_tdata);
          errors++;
        end else begin
          f = pending_faces.pop_front();
          if (out_tdata[WX_W-1:0] !== f.wx) report("word_x", out_tdata[WX_W-1:0], f.wx);
          if (out_tdata[WX_W +: RY_W] !== f.ry) report("row_y", out_tdata[WX_W +: RY_W], f.ry);
          if (out_tdata[WX_W+RY_W +: PZ_W] !== f.pz)
            report("plane_z", out_tdata[WX_W+RY_W +: PZ_W], f.pz);
          if (out_tdata[MX0 +: WORD_BITS] !== f.xn)
            report("face_xneg", out_tdata[MX0 +: WORD_BITS], f.xn);
          if (out_tdata[MX0+WORD_BITS +: WORD_BITS] !== f.xp)
            report("face_xpos", out_tdata[MX0+WORD_BITS +: WORD_BITS], f.xp);
          if (out_tdata[MX0+2*WORD_BITS +: WORD_BITS] !== f.yn)
            report("face_yneg", out_tdata[MX0+2*WORD_BITS +: WORD_BITS], f.yn);
          if (out_tdata[MX0+3*WORD_BITS +: WORD_BITS] !== f.yp)
            report("face_ypos", out_tdata[MX0+3*WORD_BITS +: WORD_BITS], f.yp);
          if (out_tdata[MX0+4*WORD_BITS +: WORD_BITS] !== f.zn)
            report("face_zneg", out_tdata[MX0+4*WORD_BITS +: WORD_BITS], f.zn);
          if (out_tdata[MX0+5*WORD_BITS +: WORD_BITS] !== f.zp)
            report("face_zpos", out_tdata[MX0+5*WORD_BITS +: WORD_BITS], f.zp);
          if (out_tlast !== f.vend) report("volume_end", out_tlast, f.vend);
        end
      end
      // one long back-pressure stretch so the command queue fills up
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (burst_mode) begin
        out_tready <= 1'b1;
      end else begin
        stall_left = pick_gap(30);
        out_tready <= (stall_left == 0);
      end
    end
  end

  // ---------------- watchdog ----------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we
        || (pending_faces.size() == 0 && !in_tvalid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("watchdog: no progress, %0d results outstanding", pending_faces.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    int rw, rp, pc, n, total;
    row_words = 8; rows_per_plane = 64; plane_count = 64;
    wpos = 0; rpos = 0; ppos = 0;

    // directed: zero registers read as one, two-word volume with extreme words
    push_cfg(vbfm_pkg::CFG_ROW_WORDS, 0);
    push_cfg(vbfm_pkg::CFG_ROWS, 0);
    push_cfg(vbfm_pkg::CFG_PLANES, 0);
    push_word('1); push_word('0);   // volume end, last plane y and z faces all set
    push_word('1); push_word('1);
    push_word(32'h8000_0001); push_word(32'h5555_5555);
    // write to the unused index leaves the stream position alone
    push_cfg(vbfm_pkg::CFG_UNUSED, 9'h1ff);
    push_word(32'hAAAA_AAAA); push_word('1);
    // x word seams and saturated row_words
    push_phase(15, 1, 2, 24);
    // saturated rows_per_plane, one plane
    push_cfg(vbfm_pkg::CFG_ROW_WORDS, 1);
    push_cfg(vbfm_pkg::CFG_ROWS, 127);
    push_cfg(vbfm_pkg::CFG_PLANES, 1);
    repeat (128) push_word(rand_word());
    // saturated plane_count, one-word planes
    push_cfg(vbfm_pkg::CFG_ROWS, 1);
    push_cfg(vbfm_pkg::CFG_PLANES, 511);
    repeat (257) push_word(rand_word());

    // random: mostly whole volumes, some truncated ones before a re-write
    total = 0;
    while (total < 280) begin
      rw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      rp = $urandom_range(1, 6);
      pc = $urandom_range(1, 4);
      n = vol_items(rw, rp, pc) * $urandom_range(1, 2) + $urandom_range(0, 5);
      total += n;
      push_phase(rw, rp, pc, n);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (stim_q.size() == 0);
    @(posedge clk);
    wait (pending_faces.size() == 0 && !in_tvalid);
    repeat (IDLE_WAIT) @(posedge clk);
    if (errors == 0 && pending_faces.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- voxel_boundary_face_mask_top.f -----
rtl/core/vbfm_pkg.sv
rtl/core/vbfm_front.sv
rtl/core/vbfm_fifo.sv
rtl/core/vbfm_back.sv
rtl/core/voxel_boundary_face_mask_top.sv
dv/tb_voxel_boundary_face_mask_top.sv
